// ===== sv/dsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal display writer package
// Shared types, constants and helper functions of the decimal display writer.
// ----------------------------------------------------------------------------
package dsw_pkg;

  // Width of the unsigned input number.
  localparam int ValueWidth = 32;
  // Width of the display position field.
  localparam int PosWidth = 3;
  // Width of the segment field.
  localparam int SegWidth = 8;
  // Width of the limit used for the too-many-digits check (10^10 < 2^34).
  localparam int LimitWidth = 36;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StWait,
    StSkip,
    StDigit
  } dsw_state_e;

  // Ten to the power n, evaluated at elaboration only.
  function automatic logic [LimitWidth-1:0] pow10(input int n);
    logic [LimitWidth-1:0] acc;
    acc = LimitWidth'(1);
    for (int i = 0; i < n; i++) begin
      acc = LimitWidth'(acc * LimitWidth'(10));
    end
    return acc;
  endfunction

  // Segment pattern of one decimal digit: bit0 A through bit6 G, bit7 point.
  function automatic logic [SegWidth-1:0] seg_of_digit(input logic [3:0] digit);
    logic [SegWidth-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== sv/dsw_dabble.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal display writer: binary to BCD converter
// Iterative shift-and-add-3 converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module dsw_dabble #(
  parameter int DIGITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dsw_pkg::ValueWidth-1:0] value_i,
  output logic                          busy_o,
  output logic [4*DIGITS-1:0]           bcd_o
);

  localparam int BcdW = 4 * DIGITS;
  localparam int CntW = $clog2(dsw_pkg::ValueWidth + 1);
  localparam logic [CntW-1:0] LastStep = CntW'(dsw_pkg::ValueWidth - 1);

  logic                           busy_q, busy_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [dsw_pkg::ValueWidth-1:0] bin_q, bin_d;
  logic [BcdW-1:0]                bcd_q, bcd_d;
  logic [BcdW-1:0]                adj;

  // Every BCD digit of five or more is corrected by three before the shift.
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[dsw_pkg::ValueWidth-1]};
      bin_d = {bin_q[dsw_pkg::ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== sv/dsw_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal display writer: write sequencer
// Emits the clear writes, then any digit writes, through an output register.
// ----------------------------------------------------------------------------
module dsw_writer #(
  parameter int DIGITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [dsw_pkg::ValueWidth-1:0] in_value_i,
  output logic                           in_ready_o,
  input  logic                           conv_busy_i,
  input  logic [4*DIGITS-1:0]            conv_bcd_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dsw_pkg::PosWidth-1:0]   out_pos_o,
  output logic [dsw_pkg::SegWidth-1:0]   out_seg_o,
  output logic                           out_last_o,
  output logic                           out_ovf_o
);

  localparam int BcdW = 4 * DIGITS;
  localparam int RemW = $clog2(DIGITS + 1);
  localparam logic [RemW-1:0] RemFull = RemW'(DIGITS);
  localparam logic [RemW-1:0] RemOne  = RemW'(1);
  localparam logic [dsw_pkg::PosWidth-1:0] PosTop =
    dsw_pkg::PosWidth'((DIGITS - 1) % (1 << dsw_pkg::PosWidth));
  localparam logic [dsw_pkg::LimitWidth-1:0] Limit = dsw_pkg::pow10(DIGITS);

  dsw_pkg::dsw_state_e state_q, state_d;

  logic                         ovf_q, ovf_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic [dsw_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [BcdW-1:0]              dig_q, dig_d;
  logic [3:0]                   top_digit;

  logic                         oval_q, oval_d;
  logic [dsw_pkg::PosWidth-1:0] opos_q, opos_d;
  logic [dsw_pkg::SegWidth-1:0] oseg_q, oseg_d;
  logic                         olast_q, olast_d;
  logic                         oovf_q, oovf_d;
  logic                         slot_free;

  assign top_digit = dig_q[BcdW-1 -: 4];
  assign slot_free = !oval_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ovf_d      = ovf_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    dig_d      = dig_q;
    oval_d     = out_ready_i ? 1'b0 : oval_q;
    opos_d     = opos_q;
    oseg_d     = oseg_q;
    olast_d    = olast_q;
    oovf_d     = oovf_q;
    in_ready_o = 1'b0;
    case (state_q)
      dsw_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ovf_d   = {{(dsw_pkg::LimitWidth - dsw_pkg::ValueWidth){1'b0}}, in_value_i}
                    >= Limit;
          rem_d   = RemFull;
          pos_d   = '0;
          state_d = dsw_pkg::StClear;
        end
      end
      dsw_pkg::StClear: begin
        if (slot_free) begin
          oval_d  = 1'b1;
          opos_d  = pos_q;
          oseg_d  = '0;
          olast_d = ovf_q && (rem_q == RemOne);
          oovf_d  = ovf_q && (rem_q == RemOne);
          pos_d   = pos_q + dsw_pkg::PosWidth'(1);
          rem_d   = rem_q - RemOne;
          if (rem_q == RemOne) begin
            if (ovf_q) begin
              state_d = dsw_pkg::StIdle;
            end else begin
              rem_d   = RemFull;
              pos_d   = PosTop;
              state_d = dsw_pkg::StWait;
            end
          end
        end
      end
      dsw_pkg::StWait: begin
        if (!conv_busy_i) begin
          dig_d   = conv_bcd_i;
          state_d = dsw_pkg::StSkip;
        end
      end
      dsw_pkg::StSkip: begin
        // Drop leading zeros; the last digit always stays.
        if ((top_digit == 4'd0) && (rem_q != RemOne)) begin
          dig_d = dig_q << 4;
          rem_d = rem_q - RemOne;
        end else begin
          state_d = dsw_pkg::StDigit;
        end
      end
      dsw_pkg::StDigit: begin
        if (slot_free) begin
          oval_d  = 1'b1;
          opos_d  = pos_q;
          oseg_d  = dsw_pkg::seg_of_digit(top_digit);
          olast_d = (rem_q == RemOne);
          oovf_d  = 1'b0;
          dig_d   = dig_q << 4;
          rem_d   = rem_q - RemOne;
          pos_d   = pos_q - dsw_pkg::PosWidth'(1);
          if (rem_q == RemOne) begin
            state_d = dsw_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = dsw_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsw_pkg::StIdle;
      oval_q  <= 1'b0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    opos_q  <= opos_d;
    oseg_q  <= oseg_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o = oval_q;
  assign out_pos_o   = opos_q;
  assign out_seg_o   = oseg_q;
  assign out_last_o  = olast_q;
  assign out_ovf_o   = oovf_q;

endmodule

// ===== sv/decimal_to_seven_segment_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal to seven-segment writer
// Turns an unsigned 32-bit number into the display writes that show it.
// ----------------------------------------------------------------------------
// Each accepted number produces DIGITS clear writes (positions 0 upward,
// segments 0), followed by one write per decimal digit without leading
// zeros, the most significant digit at position DIGITS-1 and each further
// digit one position lower; zero shows as a single '0'. The final write of
// a run carries tlast. A number above 10^DIGITS-1 yields the clear writes
// only, and its final write also carries the overflow flag in tuser. The
// block handles one number at a time and takes the next one once the last
// write of the run has entered the output register. The binary-to-BCD
// converter shifts in one input bit per cycle (it starts on the accepting
// edge and runs beside the clear writes); once it is done, its result is
// loaded, leading zeros are dropped one digit at a time, and then one
// write per digit follows. Output stalls hold back the clear and digit
// writes.
// ----------------------------------------------------------------------------
module decimal_to_seven_segment_writer_unit #(
  parameter int DIGITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input number stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  // Display write stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] position, [10:3] segments, [15:11] zero
  output logic        m_axis_tlast,   // last write of the run for this number
  output logic        m_axis_tuser    // [0] overflow
);

  logic                           conv_busy;
  logic [4*DIGITS-1:0]            conv_bcd;
  logic                           in_transfer;
  logic [dsw_pkg::PosWidth-1:0]   out_pos;
  logic [dsw_pkg::SegWidth-1:0]   out_seg;

  // The converter starts on the same edge that accepts the number.
  assign in_transfer = s_axis_tvalid && s_axis_tready;

  dsw_dabble #(
    .DIGITS(DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_transfer),
    .value_i (s_axis_tdata),
    .busy_o  (conv_busy),
    .bcd_o   (conv_bcd)
  );

  dsw_writer #(
    .DIGITS(DIGITS)
  ) u_writer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_value_i  (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .conv_busy_i (conv_busy),
    .conv_bcd_i  (conv_bcd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_seg_o   (out_seg),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  // Position in the low bits, segments above, zero padding to two bytes.
  assign m_axis_tdata = {5'd0, out_seg, out_pos};

endmodule

// ===== sv/dsw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal display writer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // A write that is held back must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled display write changed");

  // One number at a time: no transfer on the cycle after one was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while a number is in work");

  // Overflow appears only on the final write of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("overflow flag without last write");

  // The decimal point and the padding bits are never set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'd0))
    else $error("point or padding bit set in display write");

endmodule

bind decimal_to_seven_segment_writer_unit dsw_checker u_dsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/dsw_display_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display write checker
// Watches both streams of the decimal display writer, predicts the display
// writes that each accepted number causes and compares them in order.
// ----------------------------------------------------------------------------
module dsw_display_checker #(
  parameter int DIGITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [dsw_pkg::ValueWidth-1:0] in_value_i,
  input  logic                           wr_valid_i,
  input  logic                           wr_ready_i,
  input  logic [15:0]                    wr_data_i,   // [2:0] position, [10:3] segments, [15:11] zero
  input  logic                           wr_last_i,
  input  logic                           wr_flag_i,   // [0] overflow
  output int                             mismatches_o,
  output int                             outstanding_o
);

  typedef struct packed {
    logic [dsw_pkg::PosWidth-1:0] position;
    logic [dsw_pkg::SegWidth-1:0] segments;
    logic                         last_write;
    logic                         overflow;
  } display_write_t;

  // Glyphs of digits 0 to 9, digit 0 in the lowest byte.
  localparam logic [10*dsw_pkg::SegWidth-1:0] Glyphs = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  display_write_t expected_writes[$];

  // Queues the clear writes and then, unless the number is too wide, the digit
  // writes, most significant digit first, that one number produces.
  task automatic queue_writes(input logic [dsw_pkg::ValueWidth-1:0] number);
    longint unsigned ceiling;
    logic [dsw_pkg::ValueWidth-1:0] rest;
    logic [3:0] digit_q[$];
    bit too_wide;
    display_write_t w;
    ceiling = 1;
    for (int i = 0; i < DIGITS; i++) ceiling = ceiling * 10;
    too_wide = (longint'(number) >= ceiling);
    for (int i = 0; i < DIGITS; i++) begin
      w.position   = dsw_pkg::PosWidth'(i);
      w.segments   = '0;
      w.last_write = too_wide && (i == DIGITS - 1);
      w.overflow   = too_wide && (i == DIGITS - 1);
      expected_writes.push_back(w);
    end
    if (!too_wide) begin
      rest = number;
      do begin
        digit_q.push_front(4'(rest % 10));
        rest = rest / 10;
      end while (rest != 0 && digit_q.size() < DIGITS);
      for (int i = 0; i < digit_q.size(); i++) begin
        w.position   = dsw_pkg::PosWidth'(DIGITS - 1 - i);
        w.segments   = Glyphs[digit_q[i]*dsw_pkg::SegWidth +: dsw_pkg::SegWidth];
        w.last_write = (i == digit_q.size() - 1);
        w.overflow   = 1'b0;
        expected_writes.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    display_write_t seen;
    display_write_t want;
    if (!rst_ni) begin
      expected_writes.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        queue_writes(in_value_i);
      end
      if (wr_valid_i && wr_ready_i) begin
        seen.position   = wr_data_i[2:0];
        seen.segments   = wr_data_i[10:3];
        seen.last_write = wr_last_i;
        seen.overflow   = wr_flag_i;
        if (expected_writes.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: unexpected write pos=%0d seg=%02h last=%0b ovf=%0b", $realtime,
                     seen.position, seen.segments, seen.last_write, seen.overflow);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_writes.pop_front();
          if (seen != want || wr_data_i[15:11] != '0) begin
            if (mismatches_o < 10) begin
              $display("%0t: write mismatch exp pos=%0d seg=%02h last=%0b ovf=%0b", $realtime,
                       want.position, want.segments, want.last_write, want.overflow);
              $display("%0t:                got pos=%0d seg=%02h last=%0b ovf=%0b pad=%02h",
                       $realtime, seen.position, seen.segments, seen.last_write,
                       seen.overflow, wr_data_i[15:11]);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      outstanding_o <= expected_writes.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal display writer testbench
// Feeds numbers into the writer in random bursts while the display side
// stalls on its own pattern; a checker beside the block predicts and
// compares every display write.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Digits = 8;
  // Cycles without any transfer before the run is declared hung.
  localparam int WatchdogLimit = 4000;
  // Settling time after the last expected write, to catch stray writes.
  localparam int DrainCycles = 64;
  localparam int RandomItems = 440;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [2:0] position, [10:3] segments, [15:11] zero
  logic        m_axis_tlast;
  logic        m_axis_tuser;        // [0] overflow

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int stall_cycle = 0;
  int burst_left = 0;

  // Corner numbers: zero, single digits, both ends of the two- and eight-digit
  // ranges, the largest number that still fits, the first one that overflows,
  // the largest 32-bit value, inner zeros and alternating bit patterns.
  logic [31:0] corner_values[$] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000, 32'd10203040,
    32'd1234567, 32'd12345678, 32'd98765432, 32'd10000000, 32'd90000000,
    32'd99999999, 32'd100000000, 32'd100000001, 32'd1234567890,
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd5, 32'd40506
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  decimal_to_seven_segment_writer_unit #(
    .DIGITS(Digits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  dsw_display_checker #(
    .DIGITS(Digits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .wr_valid_i   (m_axis_tvalid),
    .wr_ready_i   (m_axis_tready),
    .wr_data_i    (m_axis_tdata),
    .wr_last_i    (m_axis_tlast),
    .wr_flag_i    (m_axis_tuser),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // The display side cycles through four stall behaviors: always ready,
  // mostly ready, a fixed duty cycle and a coin toss, so that stalls land on
  // clear writes and digit writes alike.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 250) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ((stall_cycle % 7) < 4);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Any transfer on either side proves the block is alive.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Once the current burst is used up, ends it with a random gap, during
  // which tvalid is low and tdata carries noise, then opens a new burst. One
  // burst in four is long, which gives stretches with no idling at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    burst_left--;
  endtask

  // Presents one number and holds it until the transfer takes place.
  task automatic send_number(input logic [31:0] number);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Most numbers get a random digit count with random content; some sit
  // right at a power of ten, and some use all 32 bits, which mostly
  // overflow and exercise every upper bit of the input.
  function automatic logic [31:0] pick_number();
    int kind;
    int width;
    longint unsigned top;
    kind  = $urandom_range(0, 9);
    width = (kind == 1) ? $urandom_range(1, 9) : $urandom_range(1, Digits);
    top   = 1;
    for (int i = 0; i < width; i++) top = top * 10;
    if (kind == 0) begin
      return $urandom;
    end else if (kind == 1) begin
      return 32'(top - 1 + $urandom_range(0, 1));
    end else begin
      return $urandom_range(32'(top - 1), (width == 1) ? 0 : 32'(top / 10));
    end
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) begin
      pace_sender();
      send_number(corner_values[i]);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Halfway through, hold off until every expected write has come out.
      if (n == RandomItems / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end else begin
        pace_sender();
      end
      send_number(pick_number());
    end

    // The count of expected writes is registered, so it is read only after the last transfer.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dsw_pkg.sv
sv/dsw_dabble.sv
sv/dsw_writer.sv
sv/decimal_to_seven_segment_writer_unit.sv
sv/dsw_checker.sv
tb/dsw_display_checker.sv
tb/tb_top.sv
